// ===== rtl/mwa_pkg.sv =====
// Shared types and fixed widths for the moving window average block.
`default_nettype none

package mwa_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 24;
  localparam int FRAC_W   = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEAN_W-1:0]   mean_t;

endpackage

`default_nettype wire

// ===== rtl/mwa_ring.sv =====
// Sample ring memory with one write port and one registered read port.
`default_nettype none

module mwa_ring #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire mwa_pkg::sample_t wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output mwa_pkg::sample_t     rd_data
);
  import mwa_pkg::*;

  sample_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; a read in the write cycle returns the old entry.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/mwa_div.sv =====
// Restoring serial divider that produces one quotient bit per cycle.
`default_nettype none

module mwa_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  busy,
  output logic [NUM_W-1:0]      quotient
);
  import mwa_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  quo;
  logic [STEP_W-1:0] steps;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              take;
  logic [DEN_W-1:0]  rem_next;

  // One trial subtraction per cycle on the shifted partial remainder.
  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    diff     = trial - {1'b0, den};
    take     = (trial >= {1'b0, den});
    rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Control: step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(NUM_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/moving_window_average_top.sv =====
// Numerator width is NUM_W = 24 + clog2(WINDOW_SIZE). Requests are handled one at a time; the
// serial divider retires one quotient bit per cycle while it is busy.
// A new request is taken once the previous result sits in the output register.
// Reset (synchronous, active high) empties the window and drops any pending result;
// ring entries keep their contents and are only read after being rewritten.
`default_nettype none

module moving_window_average_top #(
  parameter int WINDOW_SIZE = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire mwa_pkg::sample_t sample_value,
  output logic              out_valid,
  input  wire logic         out_stall,
  output mwa_pkg::mean_t    window_mean,
  output logic              window_full
);
  import mwa_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SIZE);
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W  = SAMPLE_W + SLOT_W;
  localparam int NUM_W  = SUM_W + FRAC_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_START  = 2'd2;
  localparam logic [1:0] ST_WAIT   = 2'd3;

  logic [1:0]               state;
  logic [1:0]               state_next;
  sample_t                  sample_q;
  logic [SLOT_W-1:0]        write_slot;
  logic [CNT_W-1:0]         fill_count;
  logic signed [SUM_W-1:0]  running_sum;
  logic                     full_flag;
  logic                     neg_q;

  sample_t                  old_sample;
  logic signed [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]         fill_next;
  logic [SUM_W-1:0]         sum_mag;
  logic                     div_start;
  logic                     div_busy;
  logic [NUM_W-1:0]         div_quo;
  logic [MEAN_W-1:0]        mean_mag;
  logic                     in_accept;
  logic                     out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == ST_START);

  // Sample ring, read at the slot about to be overwritten.
  mwa_ring #(
    .DEPTH  (WINDOW_SIZE),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state == ST_UPDATE),
    .wr_addr (write_slot),
    .wr_data (sample_q),
    .rd_addr (write_slot),
    .rd_data (old_sample)
  );

  // Running sum: drop the oldest sample once full, then add the new one.
  always_comb begin
    sum_next = running_sum + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
    if (full_flag) begin
      sum_next = sum_next - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
    end
    fill_next = (fill_count == CNT_W'(WINDOW_SIZE)) ? fill_count : fill_count + 1'b1;
    sum_mag   = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
  end

  // Serial divider; the divisor is the fill count, which saturates at the window size.
  mwa_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_mag, {FRAC_W{1'b0}}}),
    .divisor  (fill_count),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign mean_mag = div_quo[MEAN_W-1:0];

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_START;
      ST_START:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (!div_busy && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_slot  <= '0;
      fill_count  <= '0;
      running_sum <= '0;
      full_flag   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE) begin
        running_sum <= sum_next;
        fill_count  <= fill_next;
        full_flag   <= (fill_next == CNT_W'(WINDOW_SIZE));
        write_slot  <= (write_slot == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : write_slot + 1'b1;
      end
    end
  end

  // Request capture and sign of the mean.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_q <= sample_value;
    end
    if (state == ST_START) begin
      neg_q <= running_sum[SUM_W-1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WAIT && !div_busy && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT && !div_busy && out_free) begin
      window_mean <= neg_q ? mean_t'(-mean_mag) : mean_t'(mean_mag);
      window_full <= full_flag;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mwa_check.sv =====
// Port-level checker for the moving window average block and its bind.
`default_nettype none

module mwa_check (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_valid,
  input wire logic         in_stall,
  input wire logic         out_valid,
  input wire logic         out_stall,
  input wire mwa_pkg::mean_t window_mean,
  input wire logic         window_full
);
  import mwa_pkg::*;

  logic [1:0] pending;
  logic       full_seen;

  // Requests taken but not yet delivered, and whether a full window was reported.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      full_seen <= 1'b0;
    end else begin
      pending <= pending + {1'b0, (in_valid && !in_stall)}
                         - {1'b0, (out_valid && !out_stall)};
      if (out_valid && !out_stall && window_full) begin
        full_seen <= 1'b1;
      end
    end
  end

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(window_mean) && $stable(window_full))
    else $error("stalled result changed");

  // Every result belongs to a request, and at most two are in flight.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || pending != 2'd0) && pending != 2'd3)
    else $error("result count does not match requests");

  // Once the window is full it stays full.
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_seen |-> window_full)
    else $error("full flag dropped");

endmodule

bind moving_window_average_top mwa_check u_mwa_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .window_mean (window_mean),
  .window_full (window_full)
);

`default_nettype wire
